// ----- rtl/avgp1d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avgp1d_pkg
// Shared types and constants for the 1-D int8 average pooling unit.
// ----------------------------------------------------------------------------
package avgp1d_pkg;

  localparam int MAX_CHANNELS  = 256;
  localparam int MAX_POOL      = 16;
  localparam int MAX_OUT_WIDTH = 64;
  localparam int MAX_IN_WIDTH  = 1024;

  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int SLOT_W = $clog2(MAX_POOL);
  localparam int ADDR_W = SLOT_W + CH_W;
  localparam int DEPTH  = MAX_POOL * MAX_CHANNELS;

  localparam logic signed [7:0] S8_FLOOR = -8'sd128;
  localparam logic signed [7:0] S8_CEIL  = 8'sd127;

  localparam logic [2:0] REG_CHANNELS  = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH  = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH = 3'd2;
  localparam logic [2:0] REG_POOL_SIZE = 3'd3;
  localparam logic [2:0] REG_STRIDE    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DIV,
    S_EMIT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] avg_value;
    logic [5:0] out_position;
    logic [7:0] out_channel;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/avgp1d_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avgp1d_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module avgp1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/average_pool_1d_int8_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// average_pool_1d_int8_unit
// Streaming 1-D average pooling of int8 elements, width-major channel-minor.
// ----------------------------------------------------------------------------
// operation: each item is accepted in S_IDLE, then S_CHECK visits every output position
// plus a final check; an open window adds S_READ, a closing window also runs the shared
// divider (S_DIV) and S_EMIT, an empty window on the last row adds S_EMIT, and S_FLUSH
// follows when results are produced; a new item is taken only back in S_IDLE, after the
// previous one is through, and output stalls hold the unit in S_EMIT and S_FLUSH
// reset: synchronous rst clears counters, registers to 1, sums are not cleared
// ----------------------------------------------------------------------------
module average_pool_1d_int8_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // avg_value, out_position, out_channel, zero pad
  output logic             m_tlast
);
  import avgp1d_pkg::*;

  logic [8:0]  channels;
  logic [10:0] in_width;
  logic [6:0]  out_width;
  logic [4:0]  pool_size;
  logic [4:0]  stride;
  logic [9:0]  row;
  logic [7:0]  chan;

  state_t state, state_next;

  logic [8:0]  nch;
  logic [10:0] inw;
  logic [6:0]  outw;
  logic [4:0]  pool;
  logic [4:0]  strd;

  logic signed [15:0] v;
  logic [9:0]  r;
  logic [7:0]  c;
  logic        last_row;
  logic [6:0]  p;
  logic [10:0] start;
  logic        first_row;
  logic        closing;
  logic [4:0]  len;
  logic        neg;
  logic [15:0] quo;
  logic [3:0]  rem;
  logic [4:0]  div_cnt;
  result_t     res;
  result_t     pend;
  logic        have_pend;
  result_t     out_res;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic [11:0] win_end;
  logic        in_win;
  logic        empty_win;
  logic [15:0] sum;
  logic [15:0] abs_sum;
  logic [4:0]  trial;
  logic [7:0]  avg;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] waddr;
  logic [15:0] rdata;
  logic        ram_we;
  logic [9:0]  r_in;
  logic [7:0]  c_in;
  logic [8:0]  c_inc;

  assign nch  = (channels == 9'd0) ? 9'd1 : (channels > 9'(MAX_CHANNELS)) ?
                9'(MAX_CHANNELS) : channels;
  assign inw  = (in_width == 11'd0) ? 11'd1 : (in_width > 11'(MAX_IN_WIDTH)) ?
                11'(MAX_IN_WIDTH) : in_width;
  assign outw = (out_width == 7'd0) ? 7'd1 : (out_width > 7'(MAX_OUT_WIDTH)) ?
                7'(MAX_OUT_WIDTH) : out_width;
  assign pool = (pool_size == 5'd0) ? 5'd1 : (pool_size > 5'(MAX_POOL)) ?
                5'(MAX_POOL) : pool_size;
  assign strd = (stride == 5'd0) ? 5'd1 : stride;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == S_EMIT && have_pend) || (state == S_FLUSH));

  assign r_in  = ({1'b0, row} >= inw) ? 10'(inw - 11'd1) : row;
  assign c_in  = ({1'b0, chan} >= nch) ? 8'(nch - 9'd1) : chan;
  assign c_inc = {1'b0, c_in} + 9'd1;

  assign win_end   = ({1'b0, start} + {7'd0, pool} > {1'b0, inw}) ? {1'b0, inw} :
                     {1'b0, start} + {7'd0, pool};
  assign empty_win = start >= inw;
  assign in_win    = !empty_win && ({1'b0, r} >= start) && ({2'b0, r} < win_end);
  assign addr      = {p[SLOT_W-1:0], c};

  assign sum     = first_row ? v : rdata + v;
  assign abs_sum = sum[15] ? 16'(-sum) : sum;
  assign trial   = {rem, quo[15]};

  always_comb begin
    if (neg) begin
      avg = (quo > 16'd128) ? S8_FLOOR : 8'(-quo[7:0]);
    end else begin
      avg = (quo > 16'd127) ? S8_CEIL : quo[7:0];
    end
  end

  assign ram_we = (state == S_READ);

  avgp1d_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(sum),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_CHECK;
      S_CHECK: begin
        if (p == outw) begin
          state_next = have_pend ? S_FLUSH : S_IDLE;
        end else if (empty_win) begin
          if (last_row) state_next = S_EMIT;
        end else if (in_win) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = closing ? S_DIV : S_CHECK;
      S_DIV:   if (div_cnt == 5'd16) state_next = S_EMIT;
      S_EMIT:  if (!have_pend || out_free) state_next = S_CHECK;
      S_FLUSH: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      channels  <= 9'd1;
      in_width  <= 11'd1;
      out_width <= 7'd1;
      pool_size <= 5'd1;
      stride    <= 5'd1;
      row       <= '0;
      chan      <= '0;
      have_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNELS:  channels  <= cfg_data[8:0];
          REG_IN_WIDTH:  in_width  <= cfg_data;
          REG_OUT_WIDTH: out_width <= cfg_data[6:0];
          REG_POOL_SIZE: pool_size <= cfg_data[4:0];
          REG_STRIDE:    stride    <= cfg_data[4:0];
          default: ;
        endcase
        if (cfg_index <= REG_STRIDE) begin
          row  <= '0;
          chan <= '0;
        end
      end
      if (accept) begin
        have_pend <= 1'b0;
        if (c_inc >= nch) begin
          chan <= '0;
          row  <= ({1'b0, r_in} + 11'd1 >= inw) ? 10'd0 : r_in + 10'd1;
        end else begin
          chan <= c_inc[7:0];
        end
      end
      if (state == S_EMIT && (!have_pend || out_free)) begin
        have_pend <= 1'b1;
      end
      if (state == S_FLUSH && out_free) begin
        have_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        v        <= 16'(signed'(s_tdata));
        r        <= r_in;
        c        <= c_in;
        last_row <= ({1'b0, r_in} == inw - 11'd1);
        p        <= '0;
        start    <= '0;
      end
      S_CHECK: begin
        waddr     <= addr;
        first_row <= ({1'b0, r} == start);
        closing   <= ({2'b0, r} == win_end - 12'd1);
        len       <= 5'(win_end - {1'b0, start});
        res       <= '{avg_value: 8'd0, out_position: p[5:0], out_channel: c};
        if (p != outw && !in_win && !(empty_win && last_row)) begin
          p     <= p + 7'd1;
          start <= start + {6'd0, strd};
        end
      end
      S_READ: begin
        neg     <= sum[15];
        quo     <= abs_sum;
        rem     <= '0;
        div_cnt <= '0;
        if (!closing) begin
          p     <= p + 7'd1;
          start <= start + {6'd0, strd};
        end
      end
      S_DIV: begin
        if (div_cnt == 5'd16) begin
          res.avg_value <= avg;
        end else begin
          div_cnt <= div_cnt + 5'd1;
          if (trial >= len) begin
            rem <= 4'(trial - len);
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= trial[3:0];
            quo <= {quo[14:0], 1'b0};
          end
        end
      end
      S_EMIT: begin
        if (!have_pend || out_free) begin
          pend  <= res;
          p     <= p + 7'd1;
          start <= start + {6'd0, strd};
          if (have_pend) begin
            out_res <= pend;
            m_tlast <= 1'b0;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_res <= pend;
          m_tlast <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {2'b00, out_res.out_channel, out_res.out_position, out_res.avg_value};

endmodule
`default_nettype wire

// ----- tb/sv/average_pool_1d_int8_unit_test.sv -----
// ----------------------------------------------------------------------------
// average_pool_1d_int8_unit_test
// Runs configurations of the pooling unit, from directed to random, and
// checks every output transaction against an in-bench pooling predictor.
// Sender and receiver idle at random, in phases.
// ----------------------------------------------------------------------------
module average_pool_1d_int8_unit_test;
  import avgp1d_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [7:0] avg;
    logic [5:0] pos;
    logic [7:0] ch;
    logic       last;
  } pool_result_t;

  class pool_scoreboard;
    int unsigned  reg_ch, reg_inw, reg_outw, reg_pool, reg_stride;
    int unsigned  row, chan;
    logic [15:0]  sums [DEPTH];
    pool_result_t avg_queue[$];

    function new();
      reg_ch = 1; reg_inw = 1; reg_outw = 1; reg_pool = 1; reg_stride = 1;
      row = 0; chan = 0;
    endfunction

    function int unsigned eff(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [10:0] val);
      case (idx)
        REG_CHANNELS:  reg_ch = 32'(val[8:0]);
        REG_IN_WIDTH:  reg_inw = 32'(val[10:0]);
        REG_OUT_WIDTH: reg_outw = 32'(val[6:0]);
        REG_POOL_SIZE: reg_pool = 32'(val[4:0]);
        REG_STRIDE:    reg_stride = 32'(val[4:0]);
        default: return;
      endcase
      row = 0;
      chan = 0;
    endfunction

    function int unsigned pending();
      return avg_queue.size();
    endfunction

    function int note_input(logic signed [7:0] v);
      int unsigned nch, inw, outw, pool, strd, r, c, p, start, stop, slot;
      int s, len, a;
      bit last_row;
      pool_result_t step_res[$];
      pool_result_t item;
      nch = eff(reg_ch, MAX_CHANNELS);
      inw = eff(reg_inw, MAX_IN_WIDTH);
      outw = eff(reg_outw, MAX_OUT_WIDTH);
      pool = eff(reg_pool, MAX_POOL);
      strd = eff(reg_stride, 31);
      r = (row >= inw) ? inw - 1 : row;
      c = (chan >= nch) ? nch - 1 : chan;
      last_row = (r == inw - 1);
      for (p = 0; p < outw; p++) begin
        start = p * strd;
        item.pos = p[5:0];
        item.ch = c[7:0];
        item.last = 1'b0;
        if (start >= inw) begin
          if (last_row) begin
            item.avg = 8'd0;
            step_res.push_back(item);
          end
          continue;
        end
        stop = start + pool;
        if (stop > inw) stop = inw;
        if (r < start || r >= stop) continue;
        slot = (p % MAX_POOL) * MAX_CHANNELS + c;
        if (r == start) sums[slot] = {{8{v[7]}}, v};
        else sums[slot] = sums[slot] + {{8{v[7]}}, v};
        if (r == stop - 1) begin
          s = $signed(sums[slot]);
          len = stop - start;
          a = s / len;
          if (a < -128) a = -128;
          if (a > 127) a = 127;
          item.avg = a[7:0];
          step_res.push_back(item);
        end
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      foreach (step_res[i]) avg_queue.push_back(step_res[i]);
      c++;
      if (c >= nch) begin
        c = 0;
        r++;
        if (r >= inw) r = 0;
      end
      chan = c;
      row = r;
      return step_res.size();
    endfunction

    function string check(logic [23:0] data, logic tlast);
      pool_result_t e;
      if (avg_queue.size() == 0)
        return $sformatf("unexpected result data=%h last=%b", data, tlast);
      e = avg_queue.pop_front();
      if (data[7:0] !== e.avg || data[13:8] !== e.pos || data[21:14] !== e.ch ||
          tlast !== e.last)
        return $sformatf("got avg=%h pos=%0d ch=%0d last=%b, want avg=%h pos=%0d ch=%0d last=%b",
                         data[7:0], data[13:8], data[21:14], tlast,
                         e.avg, e.pos, e.ch, e.last);
      return "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // in_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // avg_value, out_position, out_channel, zero pad
  logic        m_tlast;

  pool_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_phases = 0;

  average_pool_1d_int8_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    n_errors++;
    $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      msg = sb.check(m_tdata, m_tlast);
      if (msg != "") report(msg);
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send(logic [7:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    void'(sb.note_input(v));
    n_items++;
  endtask

  // wait for all results, then for any item still in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic configure(int unsigned ch, int unsigned inw, int unsigned outw,
                           int unsigned pool, int unsigned strd);
    drain();
    write_reg(REG_CHANNELS, 11'(ch));
    write_reg(REG_IN_WIDTH, 11'(inw));
    write_reg(REG_OUT_WIDTH, 11'(outw));
    write_reg(REG_POOL_SIZE, 11'(pool));
    write_reg(REG_STRIDE, 11'(strd));
    n_phases++;
    case (n_phases % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  initial begin
    int unsigned ch, inw, outw, pool, strd, n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults
    send(8'h7f);
    send(8'h80);
    // clamped and empty windows
    configure(3, 5, 4, 2, 2);
    for (int i = 0; i < 8; i++) send((i % 2) ? 8'h80 : 8'h7f);
    drain();
    for (int i = 0; i < 7; i++) send(i[7:0] - 8'd3);
    // zero values act as one, oversized values saturate
    configure(0, 0, 127, 31, 31);
    send(8'hff);
    send(8'h00);
    configure(511, 2047, 2, 16, 1);
    send(8'h55);
    drain();
    write_reg(REG_UNUSED, 11'h7ff);
    send(8'haa);

    while (n_items < 440) begin
      if ($urandom_range(4) == 0) begin
        ch = $urandom_range(130, 511);
        inw = $urandom_range(0, 1);
        outw = $urandom_range(1, 3);
      end else begin
        ch = $urandom_range(0, 6);
        inw = $urandom_range(0, 12);
        outw = ($urandom_range(7) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 10);
      end
      pool = $urandom_range(0, 31);
      strd = $urandom_range(0, 31);
      configure(ch, inw, outw, pool, strd);
      if (ch > 8) n = 140;
      else n = sb.eff(ch, MAX_CHANNELS) * sb.eff(inw, MAX_IN_WIDTH) * 2 + $urandom_range(3);
      if (outw > 10 && n > 20) n = 20;
      if (n > 60 && ch <= 8) n = 60;
      if ($urandom_range(3) == 0) write_reg(3'($urandom_range(5, 7)), 11'($urandom));
      for (int i = 0; i < n; i++) send(8'($urandom));
    end

    drain();
    $display("covered %0d items and %0d results over %0d configurations",
             n_items, n_results, n_phases);
    if (n_errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
